@@ rtl/core/sle_pkg.sv @@
// Shared types and codes for the sequential list engine.
package sle_pkg;

  localparam int REQ_W = 4;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 4'd4;
  localparam logic [REQ_W-1:0] REQ_ERASE      = 4'd5;
  localparam logic [REQ_W-1:0] REQ_FIND       = 4'd6;
  localparam logic [REQ_W-1:0] REQ_MODIFY     = 4'd7;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 4'd8;

  // Result status codes
  localparam logic [ST_W-1:0] STAT_OK       = 3'd0;
  localparam logic [ST_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] STAT_BAD_POS  = 3'd3;
  localparam logic [ST_W-1:0] STAT_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_DUMP
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic find_emit;  // resolve the latched match vector into a result
    logic dump_emit;  // emit the entry at the dump pointer
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic count_zero; // list is empty
    logic dump_last;  // dump pointer sits on the last entry
  } dp_stat_t;

endpackage

@@ rtl/core/sequential_list_engine.sv @@
// Push, pop, insert, erase, modify: result registered on accept; one per cycle unless stalled.
// Find: compares all entries in parallel into a latched match vector; next request
//   taken once the result beat has been loaded into the output register.
// Dump: one beat per entry per cycle unless stalled, one if empty; input held off until done.
// Reset (rst_n low, synchronous) empties the list and clears control; entry contents are not
//   cleared and are never read before being written.
module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         out_status,
  output logic [POS_W-1:0]        out_found_position,
  output logic signed [VAL_W-1:0] out_entry_value,
  output logic [POS_W-1:0]        out_entry_count,
  output logic                    out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing
  sle_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // List storage and result beats
  sle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_req_type),
    .in_position        (in_position),
    .in_value           (in_value),
    .cmd                (cmd),
    .stat               (stat),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_value    (out_entry_value),
    .out_entry_count    (out_entry_count),
    .out_last           (out_last)
  );

endmodule

@@ rtl/core/sle_ctrl.sv @@
// Controller state machine for the sequential list engine.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] in_req_type,
  output logic             in_ready,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (cmd.accept) begin
          case (in_req_type)
            REQ_FIND: begin
              state_nxt = S_FIND;
            end
            REQ_DUMP: begin
              if (!stat.count_zero) begin
                state_nxt = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_FIND: begin
        if (stat.out_free) begin
          cmd.find_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.dump_emit = 1'b1;
          if (stat.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/sle_dp.sv @@
// Datapath: entry register array, count, match vector and output register.
module sle_dp
  import sle_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic [POS_W-1:0]        out_found_position,
  output logic signed [VAL_W-1:0] out_entry_value,
  output logic [POS_W-1:0]        out_entry_count,
  output logic                    out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [VAL_W-1:0] entries_r [DEPTH];
  logic [VAL_W-1:0] entries_nxt [DEPTH];
  logic [CW-1:0]    count_r, count_nxt;
  logic [DEPTH-1:0] match_r;
  logic [AW-1:0]    dump_ptr_r;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [POS_W-1:0] out_fpos_r;
  logic [VAL_W-1:0] out_value_r;
  logic [POS_W-1:0] out_count_r;
  logic             out_last_r;

  // Decoded request
  logic             do_open, do_close, do_write, do_match;
  logic [AW-1:0]    op_idx;
  logic             res_load;
  logic [ST_W-1:0]  res_status;
  logic [POS_W-1:0] res_fpos;
  logic [VAL_W-1:0] res_value;
  logic             res_last;
  logic [CW-1:0]    res_count;

  logic             full_w;
  logic [EW-1:0]    pos_ext, cnt_ext;
  logic             pos_ins_ok, pos_in_ok;
  logic [AW-1:0]    pos_idx, back_idx;
  logic [AW-1:0]    rd_idx;
  logic [VAL_W-1:0] rd_data;
  logic [POS_W-1:0] find_pos;

  assign full_w     = (count_r == CW'(DEPTH));
  assign pos_ext    = EW'(in_position);
  assign cnt_ext    = EW'(count_r);
  assign pos_ins_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + EW'(1));
  assign pos_in_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_idx    = AW'(in_position - POS_W'(1));
  assign back_idx   = AW'(count_r - CW'(1));

  // Entry index the request works on
  always_comb begin
    op_idx = '0;
    case (in_req_type)
      REQ_PUSH_BACK: begin
        op_idx = AW'(count_r);
      end
      REQ_POP_BACK: begin
        op_idx = back_idx;
      end
      REQ_INSERT, REQ_ERASE, REQ_MODIFY: begin
        op_idx = pos_idx;
      end
      default: begin
        op_idx = '0;
      end
    endcase
  end

  // Single read port: dump pointer while dumping, else the removal index
  assign rd_idx  = cmd.dump_emit ? dump_ptr_r : op_idx;
  assign rd_data = entries_r[rd_idx];

  // Lowest matching position from the latched match vector
  always_comb begin
    find_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        find_pos = POS_W'(i + 1);
      end
    end
  end

  // Request decode and result build
  always_comb begin
    do_open    = 1'b0;
    do_close   = 1'b0;
    do_write   = 1'b0;
    do_match   = 1'b0;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_fpos   = '0;
    res_value  = '0;
    res_last   = 1'b1;
    count_nxt  = count_r;
    if (cmd.accept) begin
      res_load = 1'b1;
      case (in_req_type)
        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
          if (full_w) begin
            res_status = STAT_FULL;
          end else begin
            do_open   = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_POP_BACK, REQ_POP_FRONT: begin
          if (count_r == '0) begin
            res_status = STAT_EMPTY;
          end else begin
            do_close  = 1'b1;
            res_value = rd_data;
            count_nxt = count_r - CW'(1);
          end
        end
        REQ_INSERT: begin
          if (!pos_ins_ok) begin
            res_status = STAT_BAD_POS;
          end else if (full_w) begin
            res_status = STAT_FULL;
          end else begin
            do_open   = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_ERASE: begin
          if (!pos_in_ok) begin
            res_status = STAT_BAD_POS;
          end else begin
            do_close  = 1'b1;
            res_value = rd_data;
            count_nxt = count_r - CW'(1);
          end
        end
        REQ_MODIFY: begin
          if (!pos_in_ok) begin
            res_status = STAT_BAD_POS;
          end else begin
            do_write = 1'b1;
          end
        end
        REQ_FIND: begin
          do_match = 1'b1;
          res_load = 1'b0;
        end
        REQ_DUMP: begin
          // Empty list answers at once; otherwise the dump state takes over
          res_status = STAT_EMPTY;
          res_load   = (count_r == '0);
        end
        default: begin
          res_load = 1'b0;
        end
      endcase
    end else if (cmd.find_emit) begin
      res_load   = 1'b1;
      res_status = (|match_r) ? STAT_OK : STAT_NOT_FOUND;
      res_fpos   = find_pos;
    end else if (cmd.dump_emit) begin
      res_load  = 1'b1;
      res_fpos  = POS_W'(dump_ptr_r) + POS_W'(1);
      res_value = rd_data;
      res_last  = stat.dump_last;
    end
    res_count = count_nxt;
  end

  // Per-entry next value: open a slot, close a slot or overwrite in place
  for (genvar i = 0; i < DEPTH; i++) begin : g_ent
    localparam logic [AW-1:0] IDX = AW'(i);
    logic [VAL_W-1:0] prev_w, next_w;
    logic             hit_w;

    if (i == 0) begin : g_first
      assign prev_w = entries_r[0];
    end else begin : g_prev
      assign prev_w = entries_r[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign next_w = entries_r[i];
    end else begin : g_next
      assign next_w = entries_r[i+1];
    end

    assign hit_w = (entries_r[i] == in_value) && (count_r > CW'(i));

    always_comb begin
      entries_nxt[i] = entries_r[i];
      if (do_open) begin
        if (IDX == op_idx) begin
          entries_nxt[i] = in_value;
        end else if (IDX > op_idx) begin
          entries_nxt[i] = prev_w;
        end
      end else if (do_close) begin
        if (IDX >= op_idx) begin
          entries_nxt[i] = next_w;
        end
      end else if (do_write) begin
        if (IDX == op_idx) begin
          entries_nxt[i] = in_value;
        end
      end
    end

    // Entry storage and match latch
    always_ff @(posedge clk) begin
      if (do_open || do_close || do_write) begin
        entries_r[i] <= entries_nxt[i];
      end
      if (do_match) begin
        match_r[i] <= hit_w;
      end
    end
  end

  // Count and dump pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      dump_ptr_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.accept) begin
        dump_ptr_r <= '0;
      end else if (cmd.dump_emit) begin
        dump_ptr_r <= dump_ptr_r + AW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_fpos_r   <= res_fpos;
      out_value_r  <= res_value;
      out_count_r  <= POS_W'(res_count);
      out_last_r   <= res_last;
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.count_zero = (count_r == '0);
  assign stat.dump_last  = (AW'(dump_ptr_r) == back_idx);

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_fpos_r;
  assign out_entry_value    = out_value_r;
  assign out_entry_count    = out_count_r;
  assign out_last           = out_last_r;

endmodule
